/* rtl/core/per_channel_interval_moving_average_unit_assert.svh */
// Assertion macros for the per-channel interval moving average unit.
// Used by per_channel_interval_moving_average_unit.sv; expects clk and rst_n in scope.
`ifndef PER_CHANNEL_INTERVAL_MOVING_AVERAGE_UNIT_ASSERT_SVH
`define PER_CHANNEL_INTERVAL_MOVING_AVERAGE_UNIT_ASSERT_SVH

`ifndef SYNTH

// Same-cycle implication.
`define PCIAM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define PCIAM_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`else

`define PCIAM_ASSERT_IMP(lbl, ante, cons, msg)
`define PCIAM_ASSERT_NXT(lbl, ante, cons, msg)

`endif

`endif

/* rtl/core/pciam_pkg.sv */
// Shared types and fixed field widths for the interval moving average unit.
// No dependencies.
`default_nettype none

package pciam_pkg;

  localparam int ACT_W   = 1;
  localparam int CHAN_W  = 6;
  localparam int STAMP_W = 31;
  localparam int AVG_W   = 32;

  // Item action codes
  localparam logic [ACT_W-1:0] ACT_UPDATE = 1'b0;
  localparam logic [ACT_W-1:0] ACT_CLEAR  = 1'b1;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_CH,
    S_RING,
    S_PREP,
    S_DIV,
    S_FIN
  } pciam_state_t;

endpackage

`default_nettype wire

/* rtl/core/per_channel_interval_moving_average_unit.sv */
// Per-channel interval moving average; uses pciam_pkg and the assert macro header.
// Flow: an accepted item passes S_CH, S_RING and S_PREP, then ITER divider steps in S_DIV,
// ITER = ceil((SUM_W+1)/8), then S_FIN, which waits for a free output register; one item
// at a time, with the 8-bit-per-cycle divider by 2*WINDOW. A clear item gives no result.
// Reset: synchronous active-low; a clearing pass over all CHANNELS entries zeroes the channel
// memory, during which in_ready stays low. The ring memory needs no clearing.
`default_nettype none
`include "per_channel_interval_moving_average_unit_assert.svh"

module per_channel_interval_moving_average_unit #(
  parameter int CHANNELS = 64,
  parameter int WINDOW   = 20
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  // input channel
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic [pciam_pkg::ACT_W-1:0]       in_action,
  input  wire logic [pciam_pkg::CHAN_W-1:0]      in_channel,
  input  wire logic [pciam_pkg::STAMP_W-1:0]     in_stamp,
  // result channel
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic                                   out_changed,
  output logic signed [pciam_pkg::AVG_W-1:0]     out_average_ms
);

  // ---------------------------------------------------------------------------
  // Derived sizes
  // ---------------------------------------------------------------------------
  localparam int CH_W       = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int PW         = $clog2(WINDOW);
  localparam int RING_DEPTH = CHANNELS * WINDOW;
  localparam int RA_W       = $clog2(RING_DEPTH);
  // Exact window sum: WINDOW values of 32 bits signed, with a spare bit.
  localparam int SUM_W      = pciam_pkg::AVG_W + 1 + $clog2(WINDOW);
  // Numerator 2*|sum| + WINDOW, padded to whole divider steps.
  localparam int NUM_W      = SUM_W + 1;
  localparam int STEPS      = 8;
  localparam int NPAD       = ((NUM_W + STEPS - 1) / STEPS) * STEPS;
  localparam int ITER       = NPAD / STEPS;
  localparam int CNT_W      = $clog2(ITER) + 1;
  // Divisor 2*WINDOW and the remainder width that holds anything below it.
  localparam int DW         = $clog2(2 * WINDOW) + 1;
  localparam logic [DW:0]   DIVISOR = (DW + 1)'(2 * WINDOW);

  // Per-channel record kept in the channel memory. full is set once the ring
  // has wrapped; until then the slot about to be overwritten reads as zero,
  // so the ring memory never needs clearing after reset or a clear item.
  typedef struct packed {
    logic                                      full;
    logic [PW-1:0]                             pos;
    logic [pciam_pkg::STAMP_W-1:0]             stamp;
    logic signed [pciam_pkg::AVG_W-1:0]        reported;
    logic signed [SUM_W-1:0]                   sum;
  } cent_t;

  // ---------------------------------------------------------------------------
  // State and datapath registers
  // ---------------------------------------------------------------------------
  pciam_pkg::pciam_state_t state_r, state_nxt;
  logic [CH_W-1:0]                      init_cnt_r, init_cnt_nxt;
  logic                                 out_valid_r, out_valid_nxt;
  logic                                 out_changed_r;
  logic signed [pciam_pkg::AVG_W-1:0]   out_avg_r;

  logic [pciam_pkg::ACT_W-1:0]          act_r;
  logic [CH_W-1:0]                      chan_r;
  logic [pciam_pkg::STAMP_W-1:0]        stamp_r;
  cent_t                                ent_r;
  logic signed [pciam_pkg::AVG_W-1:0]   interval_r;
  logic signed [SUM_W-1:0]              base_r;   // old sum + new interval
  logic signed [SUM_W-1:0]              sum_r;
  logic [RA_W-1:0]                      ring_addr_r;
  logic                                 neg_r;
  logic [DW-1:0]                        rem_r;
  logic [NPAD-1:0]                      quo_r;
  logic [CNT_W-1:0]                     cnt_r;

  // Memories
  cent_t                                cmem [CHANNELS];
  cent_t                                cm_rdata_r;
  logic [CH_W-1:0]                      cm_raddr;
  logic                                 cm_we;
  logic [CH_W-1:0]                      cm_waddr;
  cent_t                                cm_wdata;

  logic [pciam_pkg::AVG_W-1:0]          ring_mem [RING_DEPTH];
  logic [pciam_pkg::AVG_W-1:0]          ring_rdata_r;
  logic                                 ring_we;

  // Combinational helpers
  logic                                 in_fire;
  logic                                 in_range;
  logic                                 out_free;
  logic signed [pciam_pkg::AVG_W-1:0]   interval_c;
  logic [RA_W-1:0]                      ring_addr_c;
  logic signed [pciam_pkg::AVG_W-1:0]   old_c;
  logic signed [NPAD-1:0]               twice_c;
  logic [NPAD-1:0]                      num_c;
  logic [DW-1:0]                        rem_step;
  logic [NPAD-1:0]                      quo_step;
  logic signed [pciam_pkg::AVG_W-1:0]   avg_c;
  logic                                 changed_c;
  logic                                 wrap_c;
  logic [PW-1:0]                        pos_next_c;

  assign in_fire  = in_valid && in_ready;
  assign in_range = 32'(in_channel) < 32'(CHANNELS);
  assign out_free = !out_valid_r || out_ready;

  // Interval is exact in 32 bits signed since both stamps are 31-bit unsigned.
  assign interval_c  = $signed({1'b0, stamp_r}) - $signed({1'b0, cm_rdata_r.stamp});
  assign ring_addr_c = RA_W'(chan_r) * RA_W'(WINDOW) + RA_W'(cm_rdata_r.pos);
  // Slot being overwritten holds zero until the ring has wrapped once.
  assign old_c       = ent_r.full ? $signed(ring_rdata_r) : '0;

  // Rounding numerator: 2*|sum| + WINDOW, folded into one add per sign.
  assign twice_c = NPAD'(sum_r) <<< 1;
  assign num_c   = (sum_r < 0) ? (NPAD'(WINDOW) - twice_c) : (twice_c + NPAD'(WINDOW));

  // Restoring divide by 2*WINDOW, STEPS quotient bits per cycle.
  always_comb begin : div_step
    logic [DW:0]     t;
    logic [DW-1:0]   r;
    logic [NPAD-1:0] q;
    r = rem_r;
    q = quo_r;
    for (int i = 0; i < STEPS; i++) begin
      t = {r, q[NPAD-1]};
      q = {q[NPAD-2:0], 1'b0};
      if (t >= DIVISOR) begin
        t    = t - DIVISOR;
        q[0] = 1'b1;
      end
      r = t[DW-1:0];
    end
    rem_step = r;
    quo_step = q;
  end

  // Apply the sign to the quotient; its magnitude stays below 2^31.
  assign avg_c      = neg_r ? -$signed(quo_r[pciam_pkg::AVG_W-1:0])
                            : $signed(quo_r[pciam_pkg::AVG_W-1:0]);
  assign changed_c  = avg_c != ent_r.reported;
  assign wrap_c     = ent_r.pos == PW'(WINDOW - 1);
  assign pos_next_c = wrap_c ? '0 : ent_r.pos + PW'(1);

  // ---------------------------------------------------------------------------
  // Control: next state and memory strobes
  // ---------------------------------------------------------------------------
  always_comb begin
    state_nxt     = state_r;
    init_cnt_nxt  = init_cnt_r;
    out_valid_nxt = out_valid_r && !out_ready;
    in_ready      = 1'b0;
    cm_raddr      = CH_W'(in_channel);
    cm_we         = 1'b0;
    cm_waddr      = chan_r;
    cm_wdata      = '0;
    ring_we       = 1'b0;

    unique case (state_r)
      pciam_pkg::S_INIT: begin
        // Sweep the channel memory to zero, one entry a cycle.
        cm_we        = 1'b1;
        cm_waddr     = init_cnt_r;
        init_cnt_nxt = init_cnt_r + CH_W'(1);
        if (init_cnt_r == CH_W'(CHANNELS - 1)) begin
          state_nxt = pciam_pkg::S_IDLE;
        end
      end
      pciam_pkg::S_IDLE: begin
        in_ready = 1'b1;
        // Drop out-of-range channels here: nothing changes, no result.
        if (in_fire && in_range) begin
          state_nxt = pciam_pkg::S_CH;
        end
      end
      pciam_pkg::S_CH: begin
        if (act_r == pciam_pkg::ACT_CLEAR) begin
          cm_we     = 1'b1;
          state_nxt = pciam_pkg::S_IDLE;
        end else begin
          state_nxt = pciam_pkg::S_RING;
        end
      end
      pciam_pkg::S_RING: begin
        ring_we   = 1'b1;
        state_nxt = pciam_pkg::S_PREP;
      end
      pciam_pkg::S_PREP: begin
        state_nxt = pciam_pkg::S_DIV;
      end
      pciam_pkg::S_DIV: begin
        if (cnt_r == CNT_W'(ITER - 1)) begin
          state_nxt = pciam_pkg::S_FIN;
        end
      end
      pciam_pkg::S_FIN: begin
        // Hold until the output register is free, then write back and report.
        if (out_free) begin
          cm_we             = 1'b1;
          cm_wdata.full     = ent_r.full | wrap_c;
          cm_wdata.pos      = pos_next_c;
          cm_wdata.stamp    = stamp_r;
          cm_wdata.reported = avg_c;
          cm_wdata.sum      = sum_r;
          out_valid_nxt     = 1'b1;
          state_nxt         = pciam_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = pciam_pkg::S_INIT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pciam_pkg::S_INIT;
      init_cnt_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      init_cnt_r  <= init_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Datapath registers (no reset needed)
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    unique case (state_r)
      pciam_pkg::S_IDLE: begin
        if (in_fire) begin
          act_r   <= in_action;
          chan_r  <= CH_W'(in_channel);
          stamp_r <= in_stamp;
        end
      end
      pciam_pkg::S_CH: begin
        ent_r       <= cm_rdata_r;
        interval_r  <= interval_c;
        base_r      <= cm_rdata_r.sum + SUM_W'(interval_c);
        ring_addr_r <= ring_addr_c;
      end
      pciam_pkg::S_RING: begin
        sum_r <= base_r - SUM_W'(old_c);
      end
      pciam_pkg::S_PREP: begin
        neg_r <= sum_r < 0;
        rem_r <= '0;
        quo_r <= num_c;
        cnt_r <= '0;
      end
      pciam_pkg::S_DIV: begin
        rem_r <= rem_step;
        quo_r <= quo_step;
        cnt_r <= cnt_r + CNT_W'(1);
      end
      pciam_pkg::S_FIN: begin
        if (out_free) begin
          out_changed_r <= changed_c;
          out_avg_r     <= avg_c;
        end
      end
      default: begin
      end
    endcase
  end

  // Channel memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (cm_we) begin
      cmem[cm_waddr] <= cm_wdata;
    end
    cm_rdata_r <= cmem[cm_raddr];
  end

  // Ring memory: read the slot in S_CH, write the new interval back in S_RING.
  always_ff @(posedge clk) begin
    if (ring_we) begin
      ring_mem[ring_addr_r] <= interval_r;
    end
    ring_rdata_r <= ring_mem[ring_addr_c];
  end

  assign out_valid      = out_valid_r;
  assign out_changed    = out_changed_r;
  assign out_average_ms = out_avg_r;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `PCIAM_ASSERT_NXT(a_drop_range, in_fire && !in_range, state_r == pciam_pkg::S_IDLE && !$rose(out_valid), "out-of-range item must be dropped")
  `PCIAM_ASSERT_NXT(a_clear_quiet, state_r == pciam_pkg::S_CH && act_r == pciam_pkg::ACT_CLEAR, state_r == pciam_pkg::S_IDLE && !$rose(out_valid), "clear item must give no result")
  `PCIAM_ASSERT_IMP(a_pos_range, state_r == pciam_pkg::S_CH, 32'(cm_rdata_r.pos) < 32'(WINDOW), "ring position out of window")
  `PCIAM_ASSERT_IMP(a_quo_fits, state_r == pciam_pkg::S_FIN, (quo_r >> (pciam_pkg::AVG_W - 1)) == '0, "average magnitude overflow")

endmodule

`default_nettype wire
